>>> rtl/core/adw_pkg.sv
// Shared types, constants and coefficient table builders for the diffusion window.
package adw_pkg;

  // Pixel layout
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;

  // Register widths and port sizes
  localparam int IMG_W_W     = 11;
  localparam int WIN_W       = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  // Register defaults
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 11'd1024;
  localparam logic [WIN_W-1:0]   ROW_FIRST_RST   = 10'd20;
  localparam logic [WIN_W-1:0]   ROW_END_RST     = 10'd50;
  localparam logic [WIN_W-1:0]   COL_FIRST_RST   = 10'd20;
  localparam logic [WIN_W-1:0]   COL_END_RST     = 10'd30;

  // Narrowest row the line logic supports
  localparam int MIN_WIDTH = 3;

  // Diffusion constants: lambda = 1/4 is a shift by two
  localparam int LAMBDA_SHIFT = 2;
  localparam int KAPPA        = 20;
  localparam logic [63:0] KAPPA_SQ  = 64'(KAPPA) * 64'(KAPPA);
  localparam logic [63:0] Q32_ONE   = 64'h1_0000_0000;
  localparam int ROM_DEPTH    = 256;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_ROW_FIRST   = 3'd1,
    CFG_ROW_END     = 3'd2,
    CFG_COL_FIRST   = 3'd3,
    CFG_COL_END     = 3'd4,
    CFG_COEF_MODE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [WIN_W-1:0]   row_first;
    logic [WIN_W-1:0]   row_end;
    logic [WIN_W-1:0]   col_first;
    logic [WIN_W-1:0]   col_end;
    logic               mode;
  } cfg_t;

  // Control that travels with a pixel through the read stage
  typedef struct packed {
    logic             emit;
    logic             upd;
    logic             east_ok;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } stage_ctl_t;

  // Shift-subtract quotient, evaluated at elaboration only
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    int i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q32 exp(-f/m) by the alternating Taylor series, terms floored
  function automatic logic [63:0] series_exp(input logic [63:0] f, input logic [63:0] m);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    int k;
    pos  = Q32_ONE;
    neg  = '0;
    term = Q32_ONE;
    for (k = 1; k < 64; k++) begin
      if (term != 0) begin
        term = cdiv(term * f, m * 64'(k));
        if (k[0]) neg = neg + term;
        else pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // Exponential edge-stopping coefficient for absolute difference d
  function automatic logic [63:0] exp_coef(input int d, input int frac_bits);
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] e1;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] top;
    n  = 64'(d) * 64'(d);
    q  = n / KAPPA_SQ;
    f  = n % KAPPA_SQ;
    e1 = series_exp(64'd1, 64'd1);
    r  = series_exp(f, KAPPA_SQ);
    while (q != 0 && r != 0) begin
      r = (r * e1) >> 32;
      q = q - 64'd1;
    end
    v   = ((r << frac_bits) + (64'd1 << 31)) >> 32;
    top = (64'd1 << frac_bits) - 64'd1;
    return (v > top) ? top : v;
  endfunction

  // Rational coefficient m / (m + d*d), rounded half up
  function automatic logic [63:0] rat_coef(input int d, input int frac_bits);
    logic [63:0] n;
    logic [63:0] den;
    logic [63:0] v;
    logic [63:0] top;
    n   = 64'(d) * 64'(d);
    den = KAPPA_SQ + n;
    v   = cdiv((KAPPA_SQ << frac_bits) + (den >> 1), den);
    top = (64'd1 << frac_bits) - 64'd1;
    return (v > top) ? top : v;
  endfunction

endpackage

>>> rtl/core/adw_front.sv
// Position counters, the two line stores and the read stage register.
module adw_front import adw_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       frame_start,
  input  pix_t       pix_in,
  input  cfg_t       cfg,
  output stage_ctl_t ctl,
  output pix_t       center,
  output pix_t       north,
  output pix_t       south,
  output pix_t       west,
  output pix_t       east
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int FULL_W = $clog2(MAX_WIDTH + 1);
  localparam int CW     = (FULL_W > IMG_W_W) ? FULL_W : IMG_W_W;

  logic [ADDR_W-1:0] col_cnt_r;
  logic [ROW_W-1:0]  row_cnt_r;
  logic [ADDR_W-1:0] col_base;
  logic [ROW_W-1:0]  row_base;
  logic [CW-1:0]     img_w;
  logic [CW-1:0]     w_eff;
  logic [CW-1:0]     col_ext;
  logic [CW-1:0]     col_p1;
  logic              last;
  logic [ROW_W-1:0]  orow;
  logic              emit;
  logic              upd;
  logic [ADDR_W-1:0] east_addr;

  pix_t              mid_mem [MAX_WIDTH];
  pix_t              up_mem  [MAX_WIDTH];
  pix_t              mid_c_rd_r;
  pix_t              mid_e_rd_r;
  pix_t              up_rd_r;
  pix_t              pix_r;
  pix_t              west_r;
  logic              byp_r;
  logic              up_we_r;
  logic [ADDR_W-1:0] up_waddr_r;
  stage_ctl_t        ctl_r;

  // Clamp the row width into the supported range
  always_comb begin
    img_w = CW'(cfg.image_width);
    priority if (img_w < CW'(MIN_WIDTH)) begin
      w_eff = CW'(MIN_WIDTH);
    end else if (img_w > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = img_w;
    end
  end

  // Position of the incoming pixel and the window guard of the pixel above
  always_comb begin
    row_base  = frame_start ? '0 : row_cnt_r;
    col_base  = frame_start ? '0 : col_cnt_r;
    col_ext   = CW'(col_base);
    col_p1    = col_ext + CW'(1);
    last      = (col_p1 >= w_eff);
    emit      = (row_base != '0);
    orow      = row_base - ROW_W'(1);
    upd       = emit && (orow != '0) && (col_ext != '0) && !last
             && (orow >= cfg.row_first) && (orow < cfg.row_end)
             && (col_ext >= CW'(cfg.col_first)) && (col_ext < CW'(cfg.col_end));
    east_addr = last ? col_base : col_p1[ADDR_W-1:0];
  end

  // Advance the raster counters on each request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      up_we_r   <= 1'b0;
    end else begin
      up_we_r <= accept;
      if (accept) begin
        col_cnt_r <= last ? '0 : col_p1[ADDR_W-1:0];
        row_cnt_r <= last ? row_base + ROW_W'(1) : row_base;
      end
    end
  end

  // Middle line: read center and east, then store the new pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_c_rd_r        <= mid_mem[col_base];
      mid_e_rd_r        <= mid_mem[east_addr];
      mid_mem[col_base] <= pix_in;
    end
  end

  // Upper line: read north now, write the old center in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r    <= up_mem[col_base];
      up_waddr_r <= col_base;
    end
    if (up_we_r) begin
      up_mem[up_waddr_r] <= mid_c_rd_r;
    end
  end

  // Hold the window; forward a pending upper write to the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r         <= pix_in;
      west_r        <= mid_c_rd_r;
      byp_r         <= up_we_r && (up_waddr_r == col_base);
      ctl_r.emit    <= emit;
      ctl_r.upd     <= upd;
      ctl_r.east_ok <= !last;
      ctl_r.row     <= orow;
      ctl_r.col     <= COL_W'(col_base);
    end
  end

  assign ctl    = ctl_r;
  assign center = mid_c_rd_r;
  assign north  = byp_r ? west_r : up_rd_r;
  assign south  = pix_r;
  assign west   = west_r;
  assign east   = ctl_r.east_ok ? mid_e_rd_r : '0;

endmodule

>>> rtl/core/adw_lane.sv
// One channel of the diffusion update with its coefficient tables.
module adw_lane import adw_pkg::*; #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  chan_t center,
  input  chan_t north,
  input  chan_t south,
  input  chan_t west,
  input  chan_t east,
  input  logic  upd,
  input  logic  mode,
  output chan_t result
);

  localparam int SHIFT  = COEF_FRAC_BITS + LAMBDA_SHIFT;
  localparam int PROD_W = COEF_FRAC_BITS + CHAN_W + 2;
  localparam int SUM_W  = COEF_FRAC_BITS + CHAN_W + 4;

  logic [COEF_FRAC_BITS-1:0] exp_rom [ROM_DEPTH];
  logic [COEF_FRAC_BITS-1:0] rat_rom [ROM_DEPTH];
  chan_t                     nbr     [4];
  logic signed [SUM_W-1:0]   term    [4];
  logic signed [SUM_W-1:0]   ctr_term;
  logic signed [SUM_W-1:0]   total;
  logic [CHAN_W:0]           quot;
  chan_t                     clamped;

  // Build both coefficient tables from the edge threshold
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [COEF_FRAC_BITS-1:0] EXP_C =
      COEF_FRAC_BITS'(exp_coef(g, COEF_FRAC_BITS));
    localparam logic [COEF_FRAC_BITS-1:0] RAT_C =
      COEF_FRAC_BITS'(rat_coef(g, COEF_FRAC_BITS));
    assign exp_rom[g] = EXP_C;
    assign rat_rom[g] = RAT_C;
  end

  assign nbr[0] = north;
  assign nbr[1] = south;
  assign nbr[2] = west;
  assign nbr[3] = east;

  // Weight each neighbor difference by its coefficient
  for (genvar i = 0; i < 4; i++) begin : g_nbr
    logic signed [CHAN_W:0]        diff;
    logic [CHAN_W-1:0]             mag;
    logic [COEF_FRAC_BITS-1:0]     coef;
    logic signed [PROD_W-1:0]      prod;

    assign diff    = $signed({1'b0, nbr[i]}) - $signed({1'b0, center});
    assign mag     = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
    assign coef    = mode ? rat_rom[mag] : exp_rom[mag];
    assign prod    = $signed({1'b0, coef}) * diff;
    assign term[i] = SUM_W'(prod);
  end

  // Sum, scale by lambda and clamp to the pixel range
  always_comb begin
    ctr_term = $signed({2'b00, center, {SHIFT{1'b0}}});
    total    = ctr_term + term[0] + term[1] + term[2] + term[3];
    quot     = total[SUM_W-2:SHIFT];
    priority if (total[SUM_W-1]) begin
      clamped = '0;
    end else if (quot[CHAN_W]) begin
      clamped = '1;
    end else begin
      clamped = quot[CHAN_W-1:0];
    end
  end

  assign result = upd ? clamped : center;

endmodule

>>> rtl/core/anisotropic_diffusion_window.sv
// Perona-Malik diffusion window, one pass over a three-channel raster pixel stream.
// An accepted request passes the read stage register and then the result register.
// Throughput: one pixel per cycle; the input stalls only while the read stage and the
// result register both hold data and the result is stalled. Per accepted pixel the middle line
// takes two reads and one write, the upper line one read and one write.
// Reset: position counters, handshake state and configuration registers return to defaults;
// line stores keep their contents and hold no valid state.
module anisotropic_diffusion_window import adw_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAN_W-1:0]      in_chan_zero_in,
  input  logic [CHAN_W-1:0]      in_chan_one_in,
  input  logic [CHAN_W-1:0]      in_chan_two_in,
  input  logic                   in_frame_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAN_W-1:0]      out_chan_zero_out,
  output logic [CHAN_W-1:0]      out_chan_one_out,
  output logic [CHAN_W-1:0]      out_chan_two_out,
  output logic [ROW_W-1:0]       out_row,
  output logic [COL_W-1:0]       out_col,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t             cfg_r;
  logic             accept;
  logic             s1_adv;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  pix_t             pix_in;
  stage_ctl_t       ctl;
  pix_t             s1_center;
  pix_t             s1_north;
  pix_t             s1_south;
  pix_t             s1_west;
  pix_t             s1_east;
  pix_t             res_pix;
  pix_t             out_pix_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width <= IMAGE_WIDTH_RST;
      cfg_r.row_first   <= ROW_FIRST_RST;
      cfg_r.row_end     <= ROW_END_RST;
      cfg_r.col_first   <= COL_FIRST_RST;
      cfg_r.col_end     <= COL_END_RST;
      cfg_r.mode        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH: cfg_r.image_width <= cfg_data[IMG_W_W-1:0];
        CFG_ROW_FIRST:   cfg_r.row_first   <= cfg_data[WIN_W-1:0];
        CFG_ROW_END:     cfg_r.row_end     <= cfg_data[WIN_W-1:0];
        CFG_COL_FIRST:   cfg_r.col_first   <= cfg_data[WIN_W-1:0];
        CFG_COL_END:     cfg_r.col_end     <= cfg_data[WIN_W-1:0];
        CFG_COEF_MODE:   cfg_r.mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the read stage drains into the output register
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign pix_in   = {in_chan_two_in, in_chan_one_in, in_chan_zero_in};

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      s1_valid_nxt  = 1'b0;
      out_valid_nxt = s1_valid_r && ctl.emit;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  adw_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .frame_start(in_frame_start),
    .pix_in     (pix_in),
    .cfg        (cfg_r),
    .ctl        (ctl),
    .center     (s1_center),
    .north      (s1_north),
    .south      (s1_south),
    .west       (s1_west),
    .east       (s1_east)
  );

  // One update lane per channel
  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    adw_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .center(s1_center[k]),
      .north (s1_north[k]),
      .south (s1_south[k]),
      .west  (s1_west[k]),
      .east  (s1_east[k]),
      .upd   (ctl.upd),
      .mode  (cfg_r.mode),
      .result(res_pix[k])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r && ctl.emit) begin
      out_pix_r <= res_pix;
      out_row_r <= ctl.row;
      out_col_r <= ctl.col;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chan_zero_out = out_pix_r[0];
  assign out_chan_one_out  = out_pix_r[1];
  assign out_chan_two_out  = out_pix_r[2];
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;

  // An accepted request always occupies the read stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("read stage empty after an accepted request");

  // Pixels on the top row or left column are never updated
  a_upd_border: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && ctl.upd) |-> (ctl.col != '0 && ctl.row != '0))
    else $error("update flagged on an image border");

  // A pixel of the first row drains without producing a result
  a_no_emit_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && !ctl.emit) |=> !out_valid_r)
    else $error("result produced for a first-row pixel");

  // The emitted row never shows an underflowed counter
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r != '1))
    else $error("emitted row index underflowed");

endmodule

>>> sim/anisotropic_diffusion_window_tb.sv
// Self-checking testbench for the anisotropic diffusion window: raster stimulus, predictor, checker.
`timescale 1ns / 100ps

module anisotropic_diffusion_window_tb;
  import adw_pkg::*;

  localparam int LINE_LEN      = 1024;
  localparam int COEF_FRAC     = 16;
  localparam int UPDATE_SHIFT  = COEF_FRAC + LAMBDA_SHIFT;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;
  localparam int FILL_WIDTH    = 48;
  localparam longint unsigned Q32_UNIT = 64'h1_0000_0000;

  // Register indexes the block does not decode
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct {
    pix_t             px;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } out_pixel_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  chan_t                  in_chan_zero_in = '0;
  chan_t                  in_chan_one_in = '0;
  chan_t                  in_chan_two_in = '0;
  logic                   in_frame_start = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  chan_t                  out_chan_zero_out;
  chan_t                  out_chan_one_out;
  chan_t                  out_chan_two_out;
  logic [ROW_W-1:0]       out_row;
  logic [COL_W-1:0]       out_col;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state
  int unsigned exp_tbl [ROM_DEPTH];
  int unsigned rat_tbl [ROM_DEPTH];
  pix_t        upper_store [LINE_LEN] = '{default: '0};
  pix_t        middle_store [LINE_LEN] = '{default: '0};
  pix_t        west_px = '0;
  pix_t        center_px = '0;
  logic [ROW_W-1:0] row_pos = '0;
  int          col_pos = 0;
  cfg_t        model_cfg;
  out_pixel_t  due_pixels [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  anisotropic_diffusion_window #(
    .MAX_WIDTH(LINE_LEN),
    .COEF_FRAC_BITS(COEF_FRAC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_chan_zero_in(in_chan_zero_in),
    .in_chan_one_in(in_chan_one_in),
    .in_chan_two_in(in_chan_two_in),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_chan_zero_out(out_chan_zero_out),
    .out_chan_one_out(out_chan_one_out),
    .out_chan_two_out(out_chan_two_out),
    .out_row(out_row),
    .out_col(out_col),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Q32 exp(-f/m) from the alternating series, each term floored
  function automatic longint unsigned taylor_exp_q32(input longint unsigned f,
                                                     input longint unsigned m);
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned term;
    int k;
    pos  = Q32_UNIT;
    neg  = 0;
    term = Q32_UNIT;
    for (k = 1; k < 64 && term != 0; k++) begin
      term = (term * f) / (m * longint'(k));
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    return (pos > neg) ? pos - neg : 0;
  endfunction

  // Build both edge-stopping coefficient tables
  initial begin
    longint unsigned m;
    longint unsigned top;
    longint unsigned e1;
    longint unsigned n;
    longint unsigned q;
    longint unsigned r;
    longint unsigned v;
    int d;
    m   = longint'(KAPPA) * longint'(KAPPA);
    top = (64'd1 << COEF_FRAC) - 1;
    e1  = taylor_exp_q32(1, 1);
    for (d = 0; d < ROM_DEPTH; d++) begin
      n = longint'(d) * longint'(d);
      q = n / m;
      r = taylor_exp_q32(n % m, m);
      while (q > 0 && r != 0) begin
        r = (r * e1) >> 32;
        q--;
      end
      v = ((r << COEF_FRAC) + 64'h8000_0000) >> 32;
      exp_tbl[d] = 32'((v > top) ? top : v);
      v = ((m << COEF_FRAC) + (m + n) / 2) / (m + n);
      rat_tbl[d] = 32'((v > top) ? top : v);
    end
  end

  // One channel: center plus a quarter of the weighted neighbor differences
  function automatic chan_t diffuse_chan(input chan_t c, input chan_t n, input chan_t s,
                                         input chan_t w, input chan_t e, input logic mode);
    chan_t  nb [4];
    longint acc;
    longint d;
    int     idx;
    int     i;
    nb  = '{n, s, w, e};
    acc = longint'(c) <<< UPDATE_SHIFT;
    for (i = 0; i < 4; i++) begin
      d   = longint'(nb[i]) - longint'(c);
      idx = int'((d < 0) ? -d : d);
      acc += longint'(mode ? rat_tbl[idx] : exp_tbl[idx]) * d;
    end
    if (acc < 0) return '0;
    acc = acc >>> UPDATE_SHIFT;
    return (acc > 255) ? 8'd255 : chan_t'(acc);
  endfunction

  // Advance the raster position by one pixel and queue the pixel it releases
  function automatic void advance_raster(input pix_t pix, input logic fs);
    int               w;
    int               col;
    int               k;
    pix_t             north;
    pix_t             east;
    logic             upd;
    logic [ROW_W-1:0] orow;
    out_pixel_t       res;
    w = (model_cfg.image_width < MIN_WIDTH) ? MIN_WIDTH :
        (model_cfg.image_width > LINE_LEN) ? LINE_LEN : int'(model_cfg.image_width);
    if (fs) begin
      row_pos = '0;
      col_pos = 0;
    end
    col = col_pos % LINE_LEN;

    // Shift the middle-row window and read the neighbors
    west_px   = center_px;
    center_px = middle_store[col];
    north     = upper_store[col];
    east      = (col + 1 < w) ? middle_store[col + 1] : '0;
    upper_store[col]  = center_px;
    middle_store[col] = pix;

    if (row_pos >= 1) begin
      orow = row_pos - 1'b1;
      upd  = orow >= 1 && col >= 1 && col + 1 < w
          && orow >= model_cfg.row_first && orow < model_cfg.row_end
          && col >= model_cfg.col_first && col < model_cfg.col_end;
      for (k = 0; k < NUM_CHAN; k++) begin
        res.px[k] = upd ? diffuse_chan(center_px[k], north[k], pix[k], west_px[k], east[k],
                                       model_cfg.mode) : center_px[k];
      end
      res.row = orow;
      res.col = COL_W'(col);
      due_pixels.push_back(res);
    end

    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  // Offer one pixel request, hold it until accepted, then predict
  task automatic send_pixel(input chan_t c0, input chan_t c1, input chan_t c2,
                            input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_chan_zero_in <= c0;
    in_chan_one_in  <= c1;
    in_chan_two_in  <= c2;
    in_frame_start  <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_raster({c2, c1, c0}, fs);
  endtask

  // Drop valid, wait for every due pixel, then let the pipeline empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (cfg_reg_t'(idx))
      CFG_IMAGE_WIDTH: model_cfg.image_width = IMG_W_W'(value);
      CFG_ROW_FIRST:   model_cfg.row_first = WIN_W'(value);
      CFG_ROW_END:     model_cfg.row_end = WIN_W'(value);
      CFG_COL_FIRST:   model_cfg.col_first = WIN_W'(value);
      CFG_COL_END:     model_cfg.col_end = WIN_W'(value);
      CFG_COEF_MODE:   model_cfg.mode = value[0];
      default: ;
    endcase
  endtask

  // Smooth values around a base, with occasional full-range outliers
  function automatic chan_t pick_chan(input chan_t base);
    int v;
    if ($urandom_range(3) == 0) return chan_t'($urandom_range(255));
    v = int'(base) + int'($urandom_range(12)) - 6;
    return chan_t'((v < 0) ? 0 : (v > 255) ? 255 : v);
  endfunction

  // Fill both line stores across the widest random row, rational coefficients
  task automatic test_line_fill();
    int r;
    int c;
    chan_t base;
    write_reg(CFG_IMAGE_WIDTH, FILL_WIDTH);
    write_reg(CFG_ROW_FIRST, 1);
    write_reg(CFG_ROW_END, 2);
    write_reg(CFG_COL_FIRST, 1);
    write_reg(CFG_COL_END, FILL_WIDTH - 1);
    write_reg(CFG_COEF_MODE, 1);
    base = chan_t'($urandom_range(255));
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < FILL_WIDTH; c++) begin
        send_pixel(pick_chan(base), pick_chan(base), pick_chan(base), r == 0 && c == 0);
      end
    end
    settle_block();
  endtask

  // Small frame with full-swing edges; unmapped register writes are ignored
  task automatic test_directed_frame();
    int r;
    int c;
    write_reg(CFG_IMAGE_WIDTH, 5);
    write_reg(CFG_ROW_FIRST, 1);
    write_reg(CFG_ROW_END, 3);
    write_reg(CFG_COL_FIRST, 1);
    write_reg(CFG_COL_END, 4);
    write_reg(CFG_COEF_MODE, 0);
    write_reg(CFG_UNMAPPED_LO, 0);
    write_reg(CFG_UNMAPPED_HI, 2047);
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 5; c++) begin
        send_pixel(((r + c) % 2 == 1) ? 8'd255 : 8'd0, chan_t'(128 + 10 * r - 7 * c),
                   chan_t'($urandom_range(255)), r == 0 && c == 0);
      end
    end
    settle_block();
  endtask

  // Shrink the width in the middle of a row; the row ends at once
  task automatic test_width_cut();
    int i;
    write_reg(CFG_IMAGE_WIDTH, 10);
    write_reg(CFG_ROW_FIRST, 1);
    write_reg(CFG_ROW_END, 1023);
    write_reg(CFG_COL_FIRST, 1);
    write_reg(CFG_COL_END, 9);
    for (i = 0; i < 27; i++) begin
      send_pixel(chan_t'($urandom_range(255)), chan_t'($urandom_range(255)),
                 chan_t'($urandom_range(255)), i == 0);
    end
    settle_block();
    write_reg(CFG_IMAGE_WIDTH, 6);
    for (i = 0; i < 13; i++) begin
      send_pixel(chan_t'($urandom_range(255)), chan_t'($urandom_range(255)),
                 chan_t'($urandom_range(255)), 1'b0);
    end
    settle_block();
  endtask

  // Random frames, each with its own size, window and coefficient mode
  task automatic test_random_frames(input int item_goal);
    int    sent;
    int    w;
    int    rows;
    int    r;
    int    c;
    int    rf;
    int    re;
    int    cf;
    int    ce;
    int    wval;
    logic  fresh;
    chan_t base [3];
    sent = 0;
    while (sent < item_goal) begin
      w    = ($urandom_range(9) == 0) ? $urandom_range(13, FILL_WIDTH) : $urandom_range(3, 12);
      rows = $urandom_range(3, 6);
      wval = (w == 3 && $urandom_range(1) == 1) ? $urandom_range(0, 2) : w;
      case ($urandom_range(5))
        0: begin
          rf = 1;
          re = 1023;
          cf = 1;
          ce = 1023;
        end
        1: begin
          rf = $urandom_range(1, 1023);
          re = $urandom_range(1, 1023);
          cf = $urandom_range(1, 1023);
          ce = $urandom_range(1, 1023);
        end
        default: begin
          rf = $urandom_range(1, rows);
          re = $urandom_range(rf, rows + 1);
          cf = $urandom_range(1, w - 2);
          ce = $urandom_range(cf + 1, w - 1);
        end
      endcase
      write_reg(CFG_IMAGE_WIDTH, wval);
      write_reg(CFG_ROW_FIRST, rf);
      write_reg(CFG_ROW_END, re);
      write_reg(CFG_COL_FIRST, cf);
      write_reg(CFG_COL_END, ce);
      write_reg(CFG_COEF_MODE, $urandom_range(1));
      // Most frames restart the raster; a few continue the previous count
      fresh = ($urandom_range(7) != 0);
      for (c = 0; c < 3; c++) base[c] = chan_t'($urandom_range(255));
      for (r = 0; r < rows; r++) begin
        for (c = 0; c < w; c++) begin
          send_pixel(pick_chan(base[0]), pick_chan(base[1]), pick_chan(base[2]),
                     (fresh && r == 0 && c == 0) || $urandom_range(299) == 0);
          sent++;
        end
      end
      settle_block();
    end
  endtask

  // Long receiver hold-off fills the block; then a mid-frame sender pause
  task automatic test_backpressure();
    int i;
    write_reg(CFG_IMAGE_WIDTH, 16);
    write_reg(CFG_ROW_FIRST, 2);
    write_reg(CFG_ROW_END, 5);
    write_reg(CFG_COL_FIRST, 3);
    write_reg(CFG_COL_END, 12);
    write_reg(CFG_COEF_MODE, 1);
    for (i = 0; i < 96; i++) begin
      if (i == 20) begin
        hold_len = 200;
        hold_seq++;
      end
      if (i == 60) settle_block();
      send_pixel(chan_t'($urandom_range(255)), chan_t'($urandom_range(255)),
                 chan_t'($urandom_range(255)), i == 0);
    end
    settle_block();
  endtask

  // Receiver stall: random, or held high for a requested stretch
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest due pixel
  always @(posedge clk) begin
    out_pixel_t want;
    if (out_valid && !out_stall) begin
      if (due_pixels.size() == 0) begin
        note_mismatch("unexpected result at row", 0, out_row);
      end else begin
        want = due_pixels.pop_front();
        if (out_chan_zero_out !== want.px[0])
          note_mismatch("chan_zero_out", want.px[0], out_chan_zero_out);
        if (out_chan_one_out !== want.px[1])
          note_mismatch("chan_one_out", want.px[1], out_chan_one_out);
        if (out_chan_two_out !== want.px[2])
          note_mismatch("chan_two_out", want.px[2], out_chan_two_out);
        if (out_row !== want.row) note_mismatch("out_row", want.row, out_row);
        if (out_col !== want.col) note_mismatch("out_col", want.col, out_col);
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("anisotropic_diffusion_window_tb failed");
      $finish;
    end
  end

  initial begin
    model_cfg = '{image_width: IMAGE_WIDTH_RST, row_first: ROW_FIRST_RST,
                  row_end: ROW_END_RST, col_first: COL_FIRST_RST,
                  col_end: COL_END_RST, mode: 1'b0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 51;
    test_line_fill();
    test_directed_frame();
    test_width_cut();
    test_random_frames(270);

    send_idle_pct = 51;
    recv_idle_pct = 33;
    test_random_frames(270);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(270);
    test_backpressure();

    settle_block();
    if (errors == 0) begin
      $display("anisotropic_diffusion_window_tb passed");
    end else begin
      $display("anisotropic_diffusion_window_tb failed");
    end
    $finish;
  end

endmodule
